// ===== rtl/cmfuv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfuv_pkg: shared types and constants of the cube map face and uv block
// Widths of the direction, the uv coordinates, the divider chain and the
// control registers, plus the stage record passed from cell to cell.
// ----------------------------------------------------------------------------
package cmfuv_pkg;

   localparam int DIR_BITS     = 16;
   localparam int UV_FRAC_BITS = 16;

   localparam int NUM_FACES = 6;
   localparam int FACE_W    = 3;
   localparam int CODE_W    = 3;
   localparam int AXES_W    = NUM_FACES * CODE_W;

   // magnitude and sign-extended component
   localparam int MAG_W   = DIR_BITS + 1;
   // p + m before folding the sign
   localparam int SUM_W   = DIR_BITS + 2;
   // folded numerator, at most twice the major magnitude
   localparam int NUM_W   = DIR_BITS + 1;
   localparam int DVD_W   = NUM_W + UV_FRAC_BITS;
   localparam int DEN2_W  = DIR_BITS + 1;
   localparam int REM_W   = DEN2_W;
   // quotient bits, one cell each
   localparam int Q_W     = UV_FRAC_BITS + 1;
   localparam int COORD_W = UV_FRAC_BITS + 1;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = AXES_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FACE_U_AXES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FACE_V_AXES = CSR_IDX_W'(1);

   localparam logic [AXES_W-1:0] FACE_U_AXES_RESET = AXES_W'(2102);
   localparam logic [AXES_W-1:0] FACE_V_AXES_RESET = AXES_W'(171433);

   // axis select field of an axis code
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef logic [NUM_FACES-1:0][CODE_W-1:0] axes_type;

   // one lane of the restoring divider
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [Q_W-1:0]   low;
      logic [Q_W-1:0]   quo;
   } lane_type;

   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic              invalid;
      logic [DEN2_W-1:0] den2;
      lane_type          u;
      lane_type          v;
   } stage_type;

endpackage

// ===== rtl/cube_map_face_and_uv_top.sv =====
`timescale 1ns / 1ps
// pipeline: from req transfer to rsp_valid, the setup stage, 17 divider cells and
//   the output register; rsp_stall holds the output and backs up the chain
// throughput: one item per cycle unless rsp_stall holds the output; the setup stage,
//   divider cells (one quotient bit per cell) and output register hold up to 19 items
// reset: synchronous, clears all valids and loads the default face axis codes
// ----------------------------------------------------------------------------
// cube_map_face_and_uv_top: cube map face selection and face uv coordinates
// Picks the face of a direction vector and maps its projection onto the
// face's configured u and v axes to [0,1] in unsigned fixed point.
// ----------------------------------------------------------------------------
module cube_map_face_and_uv_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [cmfuv_pkg::DIR_BITS-1:0]    req_dir_x,
   input  logic signed [cmfuv_pkg::DIR_BITS-1:0]    req_dir_y,
   input  logic signed [cmfuv_pkg::DIR_BITS-1:0]    req_dir_z,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [cmfuv_pkg::FACE_W-1:0]             rsp_face_index,
   output logic [cmfuv_pkg::COORD_W-1:0]            rsp_u_coord,
   output logic [cmfuv_pkg::COORD_W-1:0]            rsp_v_coord,
   output logic                                     rsp_invalid_dir,
   input  logic                                     csr_we,
   input  logic [cmfuv_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [cmfuv_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import cmfuv_pkg::*;

   axes_type             face_u_axes_ff, face_u_axes_in;
   axes_type             face_v_axes_ff, face_v_axes_in;
   logic                 chain_valid [0:Q_W];
   logic                 chain_ready [0:Q_W];
   stage_type            chain_data  [0:Q_W];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FACE_W-1:0]    face_ff;
   logic                 invalid_ff;
   logic [COORD_W-1:0]   u_ff, v_ff;
   logic                 out_ready;

   function automatic logic [COORD_W-1:0] saturate(
      input logic [Q_W-1:0] q,
      input logic           zero
   );
      logic [COORD_W-1:0] one;
      one = {1'b1, {UV_FRAC_BITS{1'b0}}};
      if (zero) begin
         return '0;
      end
      return (COORD_W'(q) > one) ? one : COORD_W'(q);
   endfunction

   // control registers
   always_comb begin
      face_u_axes_in = face_u_axes_ff;
      face_v_axes_in = face_v_axes_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FACE_U_AXES: face_u_axes_in = csr_wdata;
            CSR_FACE_V_AXES: face_v_axes_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         face_u_axes_ff <= FACE_U_AXES_RESET;
         face_v_axes_ff <= FACE_V_AXES_RESET;
      end else begin
         face_u_axes_ff <= face_u_axes_in;
         face_v_axes_ff <= face_v_axes_in;
      end
   end

   cmfuv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_dir_x   (req_dir_x),
      .req_dir_y   (req_dir_y),
      .req_dir_z   (req_dir_z),
      .face_u_axes (face_u_axes_ff),
      .face_v_axes (face_v_axes_ff),
      .dn_valid    (chain_valid[0]),
      .dn_data     (chain_data[0]),
      .dn_ready    (chain_ready[0])
   );

   for (genvar i = 0; i < Q_W; i++) begin : g_cell
      cmfuv_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_data  (chain_data[i]),
         .up_ready (chain_ready[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_data  (chain_data[i+1]),
         .dn_ready (chain_ready[i+1])
      );
   end

   // output register, refilled while empty or on the cycle its transfer completes
   assign out_ready      = !rsp_valid_ff || !rsp_stall;
   assign chain_ready[Q_W] = out_ready;
   assign rsp_valid_in   = out_ready ? chain_valid[Q_W] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && chain_valid[Q_W]) begin
         face_ff    <= chain_data[Q_W].face;
         invalid_ff <= chain_data[Q_W].invalid;
         u_ff       <= saturate(chain_data[Q_W].u.quo, chain_data[Q_W].invalid);
         v_ff       <= saturate(chain_data[Q_W].v.quo, chain_data[Q_W].invalid);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_face_index  = face_ff;
   assign rsp_u_coord     = u_ff;
   assign rsp_v_coord     = v_ff;
   assign rsp_invalid_dir = invalid_ff;

endmodule

// ===== rtl/cmfuv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfuv_front: major axis, face and divider setup
// Picks the major axis and face, projects onto the face's u and v axes and
// registers the dividend and divisor that enter the divider chain.
// ----------------------------------------------------------------------------
module cmfuv_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [cmfuv_pkg::DIR_BITS-1:0] req_dir_x,
   input  logic signed [cmfuv_pkg::DIR_BITS-1:0] req_dir_y,
   input  logic signed [cmfuv_pkg::DIR_BITS-1:0] req_dir_z,
   input  cmfuv_pkg::axes_type                   face_u_axes,
   input  cmfuv_pkg::axes_type                   face_v_axes,
   output logic                                  dn_valid,
   output cmfuv_pkg::stage_type                  dn_data,
   input  logic                                  dn_ready
);
   import cmfuv_pkg::*;

   logic signed [MAG_W-1:0] cx, cy, cz, m;
   logic [MAG_W-1:0]        ax, ay, az, am_xy, den;
   logic [1:0]              axis;
   logic                    neg, zero;
   logic [FACE_W-1:0]       face;
   stage_type               stage_in;
   logic                    valid_ff, valid_in;
   stage_type               data_ff;
   logic                    ready;

   function automatic logic signed [MAG_W-1:0] project(
      input logic signed [MAG_W-1:0] px,
      input logic signed [MAG_W-1:0] py,
      input logic signed [MAG_W-1:0] pz,
      input logic [CODE_W-1:0]       code
   );
      logic signed [MAG_W-1:0] p;
      case (code[1:0])
         AXIS_X:  p = px;
         AXIS_Y:  p = py;
         AXIS_Z:  p = pz;
         default: p = '0;
      endcase
      return code[2] ? -p : p;
   endfunction

   // dividend (p+m)*2^F + |m| folded to the sign of m, split for the chain
   function automatic lane_type lane_setup(
      input logic signed [MAG_W-1:0] p,
      input logic signed [MAG_W-1:0] mm,
      input logic [MAG_W-1:0]        dd
   );
      logic signed [SUM_W-1:0] sum;
      logic [NUM_W-1:0]        n;
      logic [DVD_W-1:0]        dvd;
      lane_type                l;
      sum = SUM_W'(p) + SUM_W'(mm);
      if (mm[MAG_W-1]) begin
         sum = -sum;
      end
      n     = (sum > 0) ? sum[NUM_W-1:0] : '0;
      dvd   = {n, {UV_FRAC_BITS{1'b0}}} + DVD_W'(dd);
      l.rem = REM_W'(dvd[DVD_W-1:Q_W]);
      l.low = dvd[Q_W-1:0];
      l.quo = '0;
      return l;
   endfunction

   always_comb begin
      cx = MAG_W'(req_dir_x);
      cy = MAG_W'(req_dir_y);
      cz = MAG_W'(req_dir_z);
      ax = cx[MAG_W-1] ? -cx : cx;
      ay = cy[MAG_W-1] ? -cy : cy;
      az = cz[MAG_W-1] ? -cz : cz;
      // ties stay with the earlier axis
      axis  = AXIS_X;
      m     = cx;
      am_xy = ax;
      if (ay > ax) begin
         axis  = AXIS_Y;
         m     = cy;
         am_xy = ay;
      end
      den = am_xy;
      if (az > am_xy) begin
         axis = AXIS_Z;
         m    = cz;
         den  = az;
      end
      zero = (m == '0);
      neg  = m[MAG_W-1];
      face = zero ? '0 : {axis, neg};

      stage_in.face    = face;
      stage_in.invalid = zero;
      stage_in.den2    = {den[DEN2_W-2:0], 1'b0};
      stage_in.u       = lane_setup(project(cx, cy, cz, face_u_axes[face]), m, den);
      stage_in.v       = lane_setup(project(cx, cy, cz, face_v_axes[face]), m, den);
   end

   assign ready     = !valid_ff || dn_ready;
   assign req_stall = !ready;
   assign valid_in  = ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && req_valid) begin
         data_ff <= stage_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== rtl/cmfuv_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfuv_div_cell: one quotient bit of the u and v dividers
// Restoring division step for both lanes, registered, with its own valid
// and a ready that lets bubbles close up.
// ----------------------------------------------------------------------------
module cmfuv_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   input  cmfuv_pkg::stage_type up_data,
   output logic                 up_ready,
   output logic                 dn_valid,
   output cmfuv_pkg::stage_type dn_data,
   input  logic                 dn_ready
);
   import cmfuv_pkg::*;

   logic      valid_ff, valid_in;
   stage_type data_ff, data_in;

   function automatic lane_type div_step(
      input lane_type          l,
      input logic [DEN2_W-1:0] d2
   );
      logic [REM_W:0] trial;
      logic [REM_W:0] diff;
      logic           ge;
      lane_type       r;
      trial = {l.rem, l.low[Q_W-1]};
      diff  = trial - {1'b0, d2};
      ge    = trial >= {1'b0, d2};
      r.rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      r.low = {l.low[Q_W-2:0], 1'b0};
      r.quo = {l.quo[Q_W-2:0], ge};
      return r;
   endfunction

   always_comb begin
      data_in   = up_data;
      data_in.u = div_step(up_data.u, up_data.den2);
      data_in.v = div_step(up_data.v, up_data.den2);
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== sim/tb_cube_map_face_and_uv_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cube_map_face_and_uv_top: testbench of the cube map face and uv block
// Drives direction vectors through a short directed table, then random phases
// under several face axis settings. Every response transfer is compared with
// an in-order queue filled from typed rows or by a face/uv predictor. Both
// sides idle at random; one phase holds off responses to back up the input.
// ----------------------------------------------------------------------------
module tb_cube_map_face_and_uv_top;
   import cmfuv_pkg::*;

   localparam int DRAIN_CYCLES    = 25;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int WATCHDOG_LIMIT  = 2000;

   localparam logic [AXES_W-1:0] U_AXES_DEFAULT = 18'd2102;
   localparam logic [AXES_W-1:0] V_AXES_DEFAULT = 18'd171433;
   localparam logic [AXES_W-1:0] AXES_ALL_NONE  = 18'o333333;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 4'd9;

   typedef struct packed {
      logic [FACE_W-1:0]  face_index;
      logic [COORD_W-1:0] u_coord;
      logic [COORD_W-1:0] v_coord;
      logic               invalid_dir;
   } face_uv_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic signed [DIR_BITS-1:0] dir_x;
      logic signed [DIR_BITS-1:0] dir_y;
      logic signed [DIR_BITS-1:0] dir_z;
      logic [CSR_IDX_W-1:0]       csr_index;
      logic [CSR_DATA_W-1:0]      csr_data;
      logic                       has_typed;
      face_uv_type                typed_result;
   } directed_row_type;

   localparam int NUM_ROWS = 23;

   // rows that carry a typed result are checked against it, the rest against the predictor
   directed_row_type directed_rows [NUM_ROWS] = '{
      // zero vector
      '{ROW_ITEM, 16'sh0000, 16'sh0000, 16'sh0000, '0, '0, 1'b1, '{3'd0, 17'd0, 17'd0, 1'b1}},
      // axis extremes land on the face center
      '{ROW_ITEM, 16'sh7fff, 16'sh0000, 16'sh0000, '0, '0, 1'b1,
        '{3'd0, 17'd32768, 17'd32768, 1'b0}},
      '{ROW_ITEM, 16'sh8000, 16'sh0000, 16'sh0000, '0, '0, 1'b1,
        '{3'd1, 17'd32768, 17'd32768, 1'b0}},
      '{ROW_ITEM, 16'sh0000, 16'sh7fff, 16'sh0000, '0, '0, 1'b1,
        '{3'd2, 17'd32768, 17'd32768, 1'b0}},
      '{ROW_ITEM, 16'sh0000, 16'sh8000, 16'sh0000, '0, '0, 1'b1,
        '{3'd3, 17'd32768, 17'd32768, 1'b0}},
      '{ROW_ITEM, 16'sh0000, 16'sh0000, 16'sh7fff, '0, '0, 1'b1,
        '{3'd4, 17'd32768, 17'd32768, 1'b0}},
      '{ROW_ITEM, 16'sh0000, 16'sh0000, 16'sh8000, '0, '0, 1'b1,
        '{3'd5, 17'd32768, 17'd32768, 1'b0}},
      // three-way ties go to x, coordinates hit both ends
      '{ROW_ITEM, 16'sh7fff, 16'sh7fff, 16'sh7fff, '0, '0, 1'b1,
        '{3'd0, 17'd0, 17'd65536, 1'b0}},
      '{ROW_ITEM, 16'sh8000, 16'sh8000, 16'sh8000, '0, '0, 1'b1,
        '{3'd1, 17'd0, 17'd0, 1'b0}},
      '{ROW_ITEM, 16'sd1, 16'sd0, 16'sd0, '0, '0, 1'b0, '0},
      '{ROW_ITEM, -16'sd1, 16'sd1, 16'sd0, '0, '0, 1'b0, '0},
      '{ROW_ITEM, 16'sd0, -16'sd5000, 16'sd5000, '0, '0, 1'b0, '0},
      '{ROW_ITEM, 16'sd12000, -16'sd12000, 16'sd0, '0, '0, 1'b0, '0},
      '{ROW_ITEM, 16'sd3, -16'sd2, 16'sd1, '0, '0, 1'b0, '0},
      '{ROW_ITEM, -16'sd20000, 16'sd15000, -16'sd10000, '0, '0, 1'b0, '0},
      '{ROW_ITEM, 16'sd100, -16'sd32767, 16'sd8000, '0, '0, 1'b0, '0},
      '{ROW_ITEM, 16'sd0, 16'sd0, -16'sd1, '0, '0, 1'b0, '0},
      '{ROW_ITEM, 16'sh7fff, 16'sh8000, 16'sh0000, '0, '0, 1'b0, '0},
      // codes that select no axis give the center
      '{ROW_CSR, 16'sd0, 16'sd0, 16'sd0, CSR_FACE_U_AXES, 18'h3ffff, 1'b0, '0},
      '{ROW_CSR, 16'sd0, 16'sd0, 16'sd0, CSR_FACE_V_AXES, AXES_ALL_NONE, 1'b0, '0},
      '{ROW_ITEM, 16'sd12345, -16'sd300, 16'sd200, '0, '0, 1'b1,
        '{3'd0, 17'd32768, 17'd32768, 1'b0}},
      // write to an unused index must not disturb the axes
      '{ROW_CSR, 16'sd0, 16'sd0, 16'sd0, CSR_UNUSED_INDEX, 18'h00000, 1'b0, '0},
      '{ROW_ITEM, -16'sd7, 16'sd3, -16'sd9, '0, '0, 1'b1,
        '{3'd5, 17'd32768, 17'd32768, 1'b0}}
   };

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [DIR_BITS-1:0] req_dir_x;
   logic signed [DIR_BITS-1:0] req_dir_y;
   logic signed [DIR_BITS-1:0] req_dir_z;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [FACE_W-1:0]          rsp_face_index;
   logic [COORD_W-1:0]         rsp_u_coord;
   logic [COORD_W-1:0]         rsp_v_coord;
   logic                       rsp_invalid_dir;
   logic                       csr_we;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   // typed expectation travels alongside the request payload
   logic        drv_has_typed;
   face_uv_type drv_typed;

   bit idle_on      = 1'b1;
   bit hold_off_req = 1'b0;
   int fail_count   = 0;

   axes_type    u_axes_now;
   axes_type    v_axes_now;
   face_uv_type face_uv_expected [$];

   cube_map_face_and_uv_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_dir_z       (req_dir_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_face_index  (rsp_face_index),
      .rsp_u_coord     (rsp_u_coord),
      .rsp_v_coord     (rsp_v_coord),
      .rsp_invalid_dir (rsp_invalid_dir),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint mag_of(longint value);
      return (value < 0) ? -value : value;
   endfunction

   function automatic longint axis_projection(longint cx, longint cy, longint cz,
                                              logic [CODE_W-1:0] code);
      longint p;
      case (code[1:0])
         AXIS_X:  p = cx;
         AXIS_Y:  p = cy;
         AXIS_Z:  p = cz;
         default: p = 0;
      endcase
      return code[2] ? -p : p;
   endfunction

   // round((p + m) / 2m * 2^frac), halves up, saturated to one
   function automatic logic [COORD_W-1:0] face_coord(longint p, longint m);
      longint num;
      longint den;
      longint q;
      num = p + m;
      if (m < 0) begin
         num = -num;
         den = -m;
      end else begin
         den = m;
      end
      if (num <= 0) return '0;
      q = ((num <<< UV_FRAC_BITS) + den) / (2 * den);
      if (q > (longint'(1) <<< UV_FRAC_BITS)) q = longint'(1) <<< UV_FRAC_BITS;
      return COORD_W'(q);
   endfunction

   function automatic face_uv_type predict_face_uv(logic signed [DIR_BITS-1:0] dx,
                                                   logic signed [DIR_BITS-1:0] dy,
                                                   logic signed [DIR_BITS-1:0] dz,
                                                   axes_type ua, axes_type va);
      longint            cx;
      longint            cy;
      longint            cz;
      longint            m;
      logic [1:0]        axis;
      logic [FACE_W-1:0] face;
      face_uv_type       r;
      cx = dx;
      cy = dy;
      cz = dz;
      r = '0;
      // ties keep the earlier axis
      axis = AXIS_X;
      m = cx;
      if (mag_of(cy) > mag_of(m)) begin
         axis = AXIS_Y;
         m = cy;
      end
      if (mag_of(cz) > mag_of(m)) begin
         axis = AXIS_Z;
         m = cz;
      end
      if (m == 0) begin
         r.invalid_dir = 1'b1;
         return r;
      end
      face = {axis, m < 0};
      r.face_index = face;
      r.u_coord = face_coord(axis_projection(cx, cy, cz, ua[face]), m);
      r.v_coord = face_coord(axis_projection(cx, cy, cz, va[face]), m);
      return r;
   endfunction

   function automatic logic signed [DIR_BITS-1:0] signed_of(int mag);
      if (mag >= 32768) return 16'sh8000;
      return $urandom_range(0, 1) ? DIR_BITS'(-mag) : DIR_BITS'(mag);
   endfunction

   task automatic gen_dir(output logic signed [DIR_BITS-1:0] x,
                          output logic signed [DIR_BITS-1:0] y,
                          output logic signed [DIR_BITS-1:0] z);
      int                         roll;
      int                         mag;
      int                         a;
      logic signed [DIR_BITS-1:0] c [3];
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
         for (int i = 0; i < 3; i++) c[i] = DIR_BITS'($urandom);
      end else if (roll < 6) begin
         // two or three components share the largest magnitude
         mag = $urandom_range(0, 32768);
         for (int i = 0; i < 3; i++) c[i] = signed_of($urandom_range(0, mag));
         a = $urandom_range(0, 3);
         if (a == 3) begin
            for (int i = 0; i < 3; i++) c[i] = signed_of(mag);
         end else begin
            c[a] = signed_of(mag);
            c[(a + 1) % 3] = signed_of(mag);
         end
      end else if (roll < 7) begin
         for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 5))
               0:       c[i] = 16'sh7fff;
               1:       c[i] = 16'sh8000;
               2:       c[i] = 16'sh0000;
               3:       c[i] = 16'sh0001;
               4:       c[i] = 16'shffff;
               default: c[i] = 16'sh8001;
            endcase
         end
      end else if (roll < 8) begin
         for (int i = 0; i < 3; i++) c[i] = DIR_BITS'($urandom_range(0, 8)) - 16'sd4;
      end else begin
         a = $urandom_range(0, 2);
         mag = $urandom_range(1, 32768);
         for (int i = 0; i < 3; i++) c[i] = signed_of($urandom_range(0, mag - 1));
         c[a] = signed_of(mag);
      end
      x = c[0];
      y = c[1];
      z = c[2];
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_dir(input logic signed [DIR_BITS-1:0] x,
                           input logic signed [DIR_BITS-1:0] y,
                           input logic signed [DIR_BITS-1:0] z,
                           input logic has_typed, input face_uv_type typed_result);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_dir_x     <= x;
      req_dir_y     <= y;
      req_dir_z     <= z;
      drv_has_typed <= has_typed;
      drv_typed     <= typed_result;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (face_uv_expected.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_axes(input logic [AXES_W-1:0] u, input logic [AXES_W-1:0] v);
      req_valid <= 1'b0;
      wait_idle();
      write_csr(CSR_FACE_U_AXES, u);
      write_csr(CSR_FACE_V_AXES, v);
      if ($urandom_range(0, 1))
         write_csr(CSR_IDX_W'($urandom_range(CSR_FACE_V_AXES + 1, 15)), CSR_DATA_W'($urandom));
   endtask

   task automatic run_random(input int count);
      logic signed [DIR_BITS-1:0] x;
      logic signed [DIR_BITS-1:0] y;
      logic signed [DIR_BITS-1:0] z;
      for (int i = 0; i < count; i++) begin
         gen_dir(x, y, z);
         send_dir(x, y, z, 1'b0, '0);
      end
   endtask

   // response side: random stall bursts, one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   // checks each response transfer, then records request and register transfers
   always @(posedge clock) begin
      face_uv_type want;
      if (reset) begin
         u_axes_now = U_AXES_DEFAULT;
         v_axes_now = V_AXES_DEFAULT;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (face_uv_expected.size() == 0) begin
               $error("response transfer with nothing expected: face_index %0d", rsp_face_index);
               fail_count++;
            end else begin
               want = face_uv_expected.pop_front();
               if (rsp_face_index !== want.face_index) begin
                  $error("face_index: expected %0d, actual %0d", want.face_index, rsp_face_index);
                  fail_count++;
               end
               if (rsp_u_coord !== want.u_coord) begin
                  $error("u_coord: expected %0d, actual %0d", want.u_coord, rsp_u_coord);
                  fail_count++;
               end
               if (rsp_v_coord !== want.v_coord) begin
                  $error("v_coord: expected %0d, actual %0d", want.v_coord, rsp_v_coord);
                  fail_count++;
               end
               if (rsp_invalid_dir !== want.invalid_dir) begin
                  $error("invalid_dir: expected %0d, actual %0d",
                         want.invalid_dir, rsp_invalid_dir);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (drv_has_typed)
               face_uv_expected.push_back(drv_typed);
            else
               face_uv_expected.push_back(predict_face_uv(req_dir_x, req_dir_y, req_dir_z,
                                                          u_axes_now, v_axes_now));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_FACE_U_AXES: u_axes_now = csr_wdata;
               CSR_FACE_V_AXES: v_axes_now = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // ends the run when no transfer happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_dir_x     = '0;
      req_dir_y     = '0;
      req_dir_z     = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      drv_has_typed = 1'b0;
      drv_typed     = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < NUM_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            req_valid <= 1'b0;
            wait_idle();
            write_csr(directed_rows[r].csr_index, directed_rows[r].csr_data);
         end else begin
            send_dir(directed_rows[r].dir_x, directed_rows[r].dir_y, directed_rows[r].dir_z,
                     directed_rows[r].has_typed, directed_rows[r].typed_result);
         end
      end

      set_axes(U_AXES_DEFAULT, V_AXES_DEFAULT);
      run_random(150);
      set_axes('0, '0);
      run_random(100);
      set_axes(18'h3ffff, 18'h3ffff);
      run_random(100);
      // long hold-off on the response side backs the pipe up into the input
      set_axes(AXES_W'($urandom), AXES_W'($urandom));
      hold_off_req = 1'b1;
      run_random(150);
      set_axes(AXES_ALL_NONE, AXES_W'($urandom));
      run_random(100);
      for (int k = 0; k < 5; k++) begin
         set_axes(AXES_W'($urandom), AXES_W'($urandom));
         run_random(90);
      end
      // full rate on both sides to finish
      idle_on = 1'b0;
      set_axes(AXES_W'($urandom), AXES_W'($urandom));
      run_random(150);

      req_valid <= 1'b0;
      wait_idle();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
